### rtl/core/dhhs_pkg.sv
// ----------------------------------------------------------------------------
// dhhs_pkg
// Shared types and constants of the dictionary heavy-hitter selector.
// ----------------------------------------------------------------------------
package dhhs_pkg;

  // Default sizes
  localparam int DICT_DEPTH_DEF  = 1024;
  localparam int GROUP_WIDTH_DEF = 64;
  localparam int MAX_AW          = 16;

  // Field and state widths
  localparam int CNT_W   = 32;
  localparam int THR_W   = 32;
  localparam int BUD_W   = 30;
  localparam int QUOTA_W = 13;
  localparam int ENT_W   = 11;
  localparam int MASK_W  = 64;
  localparam int K_W     = 9;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 10;

  // Low-cardinality test: rows / entries > 10 is rows >= 11 * entries
  localparam logic [ENT_W-1:0] LOW_CARD_MAX_ENTRIES = 11'd1000;
  localparam logic [31:0]      LOW_CARD_MIN_ROWS    = 32'd20000;
  localparam logic [31:0]      LOW_CARD_RATIO       = 32'd11;

  // Commands
  typedef enum logic [1:0] {
    CMD_NEW_DICT = 2'd0,
    CMD_BATCH    = 2'd1,
    CMD_ROW      = 2'd2,
    CMD_SCAN     = 2'd3
  } cmd_e;

  // One counter memory word
  typedef struct packed {
    logic             mark;
    logic [CNT_W-1:0] count;
  } entry_t;

  // Memory access request
  typedef struct packed {
    logic              we;
    logic [MAX_AW-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [MAX_AW-1:0] raddr;
  } mem_req_t;

  // Divider start request
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

### rtl/core/dhhs_mem.sv
// ----------------------------------------------------------------------------
// dhhs_mem
// Counter and mark store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dhhs_mem
  import dhhs_pkg::*;
#(
  parameter int DEPTH = DICT_DEPTH_DEF
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  localparam int AW = $clog2(DEPTH);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/dhhs_div.sv
// ----------------------------------------------------------------------------
// dhhs_div
// Restoring divider, one quotient bit per cycle, for the threshold update.
// ----------------------------------------------------------------------------
module dhhs_div
  import dhhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### rtl/core/dictionary_heavy_hitter_selector.sv
// ----------------------------------------------------------------------------
// dictionary_heavy_hitter_selector
// Counts dictionary entries of sampled rows and selects frequent ones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command beat; output
//   channel (out_valid_o / out_ready_i) returns exactly one result beat each.
//   cfg_we_i / cfg_wdata_i write column_enabled; the user must write it only
//   while the block is idle; the block does not enforce it. Per command:
//     row           direct, or a read-modify-write of one counter
//     scan          one memory read per entry of the group
//     batch start   threshold update on the 33-step serial divider
//     new dict      direct, or a sweep of the memory when counters are cleared
//     disabled      direct to the result
//   One command is processed at a time; the counter memory port paces it.
//   After reset the block sweeps the counter memory to zero, in_ready_o low.
//   A result held by a stalled receiver stays in the output register; the
//   next command is taken and finishes into a pending stage meanwhile.
// ----------------------------------------------------------------------------
module dictionary_heavy_hitter_selector
  import dhhs_pkg::*;
#(
  parameter int DICT_DEPTH  = DICT_DEPTH_DEF,
  parameter int GROUP_WIDTH = GROUP_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [10:0]       dict_entries_i,
  input  logic [31:0]       encoded_rows_i,
  input  logic [12:0]       batch_rows_i,
  input  logic [9:0]        row_entry_i,
  input  logic [3:0]        group_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              insert_all_o,
  output logic [MASK_W-1:0] selected_mask_o,
  output logic [THR_W-1:0]  threshold_now_o,
  output logic [BUD_W-1:0]  budget_left_o
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int JW = $clog2(GROUP_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ROW, ST_SCAN, ST_DIV, ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic                 enabled_q, enabled_d;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic [BUD_W-1:0]     budget_q, budget_d;
  logic [QUOTA_W-1:0]   quota_q, quota_d;
  logic [31:0]          seen_q, seen_d;
  logic [ENT_W-1:0]     eiu_q, eiu_d;
  logic                 low_q, low_d;
  logic [3:0]           group_q, group_d;
  logic [JW-1:0]        rd_j_q, rd_j_d;
  logic                 p_vld_q, p_vld_d;
  logic                 p_in_q, p_in_d;
  logic [JW-1:0]        p_j_q, p_j_d;
  logic [AW-1:0]        p_addr_q, p_addr_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic                 res_ins_q, res_ins_d;
  logic                 res_zero_q, res_zero_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic                 clr_out_q, clr_out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_ins_q, out_ins_d;
  logic [MASK_W-1:0]    out_mask_q, out_mask_d;
  logic [THR_W-1:0]     out_thr_q, out_thr_d;
  logic [BUD_W-1:0]     out_bud_q, out_bud_d;

  mem_req_t             mreq;
  entry_t               rdata;
  div_req_t             dreq;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;

  logic                 accept;
  logic                 low_card;
  logic [BUD_W-1:0]     take;
  logic [32:0]          seen_sum;
  logic [31:0]          seen_new;
  logic [K_W-1:0]       k;
  logic [ENT_W-1:0]     scan_e;

  dhhs_mem #(
    .DEPTH (DICT_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  dhhs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Command-side helpers
  always_comb begin
    low_card = (dict_entries_i != '0) && (dict_entries_i <= LOW_CARD_MAX_ENTRIES) &&
               ((32'(dict_entries_i) * LOW_CARD_RATIO) <= encoded_rows_i) &&
               (encoded_rows_i > LOW_CARD_MIN_ROWS);
    take     = ({17'b0, batch_rows_i} < budget_q) ? {17'b0, batch_rows_i} : budget_q;
    seen_sum = {1'b0, seen_q} + 33'(take);
    seen_new = seen_sum[32] ? '1 : seen_sum[31:0];
    k        = K_W'(eiu_q >> 2);
    scan_e   = ENT_W'(group_q) * ENT_W'(GROUP_WIDTH) + ENT_W'(rd_j_q);
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    enabled_d   = cfg_we_i ? cfg_wdata_i : enabled_q;
    thr_d       = thr_q;
    budget_d    = budget_q;
    quota_d     = quota_q;
    seen_d      = seen_q;
    eiu_d       = eiu_q;
    low_d       = low_q;
    group_d     = group_q;
    rd_j_d      = rd_j_q;
    p_vld_d     = p_vld_q;
    p_in_d      = p_in_q;
    p_j_d       = p_j_q;
    p_addr_d    = p_addr_q;
    mask_d      = mask_q;
    res_ins_d   = res_ins_q;
    res_zero_d  = res_zero_q;
    clr_addr_d  = clr_addr_q;
    clr_out_d   = clr_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ins_d   = out_ins_q;
    out_mask_d  = out_mask_q;
    out_thr_d   = out_thr_q;
    out_bud_d   = out_bud_q;
    mreq        = '0;
    dreq        = '0;

    case (state_q)
      // Sweep the counter memory to zero
      ST_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = MAX_AW'(clr_addr_q);
        if (clr_addr_q == AW'(DICT_DEPTH - 1)) begin
          state_d = clr_out_q ? ST_OUT : ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          res_zero_d = 1'b0;
          res_ins_d  = 1'b0;
          mask_d     = '0;
          state_d    = ST_OUT;
          if (!enabled_q) begin
            res_zero_d = 1'b1;
          end else if (cmd_e'(cmd_i) == CMD_NEW_DICT) begin
            eiu_d = ({6'b0, dict_entries_i} > 17'(DICT_DEPTH)) ? ENT_W'(DICT_DEPTH)
                                                               : dict_entries_i;
            quota_d = '0;
            if (low_card) begin
              res_ins_d = 1'b1;
              low_d     = 1'b1;
              budget_d  = '0;
            end else begin
              seen_d     = '0;
              thr_d      = THR_W'(1);
              low_d      = 1'b0;
              budget_d   = encoded_rows_i[31:2];
              clr_addr_d = '0;
              clr_out_d  = 1'b1;
              state_d    = ST_CLEAR;
            end
          end else if (!low_q) begin
            case (cmd_e'(cmd_i))
              CMD_BATCH: begin
                budget_d   = budget_q - take;
                quota_d    = QUOTA_W'(take);
                seen_d     = seen_new;
                dreq.start = 1'b1;
                dreq.num   = {1'b0, seen_new} + NUM_W'(k);
                dreq.den   = DEN_W'(k) + 1'b1;
                state_d    = ST_DIV;
              end
              CMD_ROW: begin
                if (quota_q != '0) begin
                  quota_d = quota_q - 1'b1;
                  if ({1'b0, row_entry_i} < eiu_q) begin
                    mreq.re    = 1'b1;
                    mreq.raddr = MAX_AW'(row_entry_i);
                    p_addr_d   = AW'(row_entry_i);
                    state_d    = ST_ROW;
                  end
                end
              end
              CMD_SCAN: begin
                group_d = group_index_i;
                rd_j_d  = '0;
                p_vld_d = 1'b0;
                state_d = ST_SCAN;
              end
              default: begin
                state_d = ST_OUT;
              end
            endcase
          end
        end
      end

      // Saturating increment of the read counter
      ST_ROW: begin
        mreq.we          = 1'b1;
        mreq.waddr       = MAX_AW'(p_addr_q);
        mreq.wdata.mark  = rdata.mark;
        mreq.wdata.count = (rdata.count == '1) ? rdata.count : rdata.count + 1'b1;
        state_d          = ST_OUT;
      end

      // Read one entry per cycle, test and mark the previous one
      ST_SCAN: begin
        if (rd_j_q < JW'(GROUP_WIDTH)) begin
          mreq.re    = 1'b1;
          mreq.raddr = MAX_AW'(scan_e);
          p_vld_d    = 1'b1;
          p_in_d     = (scan_e != '0) && (scan_e < eiu_q);
          p_j_d      = rd_j_q;
          p_addr_d   = AW'(scan_e);
          rd_j_d     = rd_j_q + 1'b1;
        end else begin
          p_vld_d = 1'b0;
        end
        if (p_vld_q && p_in_q && (rdata.count >= thr_q) && !rdata.mark) begin
          mreq.we             = 1'b1;
          mreq.waddr          = MAX_AW'(p_addr_q);
          mreq.wdata.mark     = 1'b1;
          mreq.wdata.count    = rdata.count;
          mask_d[6'(p_j_q)]   = 1'b1;
        end
        if ((rd_j_q == JW'(GROUP_WIDTH)) && !p_vld_q) begin
          state_d = ST_OUT;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          thr_d   = (div_quot == '0) ? THR_W'(1) : div_quot[THR_W-1:0];
          state_d = ST_OUT;
        end
      end

      // Move the result into the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ins_d   = res_zero_q ? 1'b0 : res_ins_q;
          out_mask_d  = res_zero_q ? '0 : mask_q;
          out_thr_d   = res_zero_q ? '0 : thr_q;
          out_bud_d   = res_zero_q ? '0 : budget_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      enabled_q   <= 1'b0;
      thr_q       <= THR_W'(1);
      budget_q    <= '0;
      quota_q     <= '0;
      seen_q      <= '0;
      eiu_q       <= '0;
      low_q       <= 1'b0;
      rd_j_q      <= '0;
      p_vld_q     <= 1'b0;
      clr_addr_q  <= '0;
      clr_out_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      enabled_q   <= enabled_d;
      thr_q       <= thr_d;
      budget_q    <= budget_d;
      quota_q     <= quota_d;
      seen_q      <= seen_d;
      eiu_q       <= eiu_d;
      low_q       <= low_d;
      rd_j_q      <= rd_j_d;
      p_vld_q     <= p_vld_d;
      clr_addr_q  <= clr_addr_d;
      clr_out_q   <= clr_out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    group_q    <= group_d;
    p_in_q     <= p_in_d;
    p_j_q      <= p_j_d;
    p_addr_q   <= p_addr_d;
    mask_q     <= mask_d;
    res_ins_q  <= res_ins_d;
    res_zero_q <= res_zero_d;
    out_ins_q  <= out_ins_d;
    out_mask_q <= out_mask_d;
    out_thr_q  <= out_thr_d;
    out_bud_q  <= out_bud_d;
  end

  assign out_valid_o     = out_valid_q;
  assign insert_all_o    = out_ins_q;
  assign selected_mask_o = out_mask_q;
  assign threshold_now_o = out_thr_q;
  assign budget_left_o   = out_bud_q;

endmodule

### rtl/core/dhhs_checker.sv
// ----------------------------------------------------------------------------
// dhhs_checker
// Port-level assertions for the heavy-hitter selector, bound to the top.
// ----------------------------------------------------------------------------
module dhhs_checker
  import dhhs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              insert_all_o,
  input logic [MASK_W-1:0] selected_mask_o,
  input logic [THR_W-1:0]  threshold_now_o,
  input logic [BUD_W-1:0]  budget_left_o
);

  // Stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(selected_mask_o) && $stable(threshold_now_o))
    else $error("result payload changed under stall");

  // Low-cardinality flag comes with no mask and no budget
  a_insert_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && insert_all_o |-> selected_mask_o == '0 && budget_left_o == '0)
    else $error("insert_all with mask or budget");

  // Zero threshold only on a disabled column, where all fields are zero
  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && threshold_now_o == '0 |->
      !insert_all_o && selected_mask_o == '0 && budget_left_o == '0)
    else $error("partial result on disabled column");

endmodule

bind dictionary_heavy_hitter_selector dhhs_checker u_dhhs_checker (.*);
